[rtl/core/prs_pkg.sv]
// prs_pkg: shared types and constants for the primitive root search block
// used by primitive_root_search; no dependencies
package prs_pkg;

    localparam int unsigned DEF_VALUE_WIDTH = 32;
    localparam int unsigned DEF_MAX_FACTORS = 9;
    localparam int unsigned FIELD_WIDTH     = 32;

    typedef enum logic [1:0] {
        STAT_FOUND     = 2'd0,
        STAT_NOT_PRIME = 2'd1,
        STAT_TWO       = 2'd2,
        STAT_NONE      = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PT_CHK,
        S_PT_D3,
        S_PT_SQ,
        S_PT_CMP,
        S_PT_DA,
        S_PT_DB,
        S_FA_SH,
        S_FA_SQ,
        S_FA_CMP,
        S_FA_DIV,
        S_FA_TAIL,
        S_SR_FAC,
        S_SR_RD,
        S_SR_DIV,
        S_PW_CHK,
        S_PW_MA,
        S_PW_MB,
        S_PW_END,
        S_FIN
    } state_t;

endpackage

[rtl/core/prs_div.sv]
// prs_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder; no dependencies beyond its parameter
module prs_div #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quot,
    output logic [VALUE_WIDTH-1:0] rem
);
    localparam int unsigned CW = $clog2(VALUE_WIDTH);

    logic                   busy_reg, done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] rem_reg, quo_reg, dvs_reg;
    logic [VALUE_WIDTH:0]   trial, diff;
    logic                   ge;

    // one restoring step
    always_comb begin
        trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(VALUE_WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule

[rtl/core/prs_mulmod.sv]
// prs_mulmod: bit-serial modular multiplier a*b mod m, operands below m
// one bit of b per cycle, most significant first; no dependencies
module prs_mulmod #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    input  logic [VALUE_WIDTH-1:0] m,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] res
);
    localparam int unsigned CW = $clog2(VALUE_WIDTH);

    logic                   busy_reg, done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] a_reg, b_reg, m_reg, acc_reg;
    logic [VALUE_WIDTH:0]   dbl, dbl_r, sum, sum_r;

    // acc = 2*acc + bit*a, reduced after each add
    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum   = dbl_r + (b_reg[VALUE_WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_r = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(VALUE_WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= sum_r[VALUE_WIDTH-1:0];
            b_reg   <= {b_reg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;
endmodule

[rtl/core/primitive_root_search.sv]
// primitive_root_search: smallest primitive root above a bound modulo a prime
// uses prs_pkg, prs_div and prs_mulmod
//
//   channel | ports                                  | direction
//   s_      | s_prime_candidate, s_lower_bound       | in
//   m_      | m_root, m_status                       | out
//
// one item at a time; s_ready is high only while the sequencer is idle
// cycles per item are data dependent: every trial division and every
// modular multiply runs in the shared divider or multiplier, and
// the search costs about 2*VALUE_WIDTH multiplies per factor
// exponentiation per candidate
// a finished result sits in the output register until taken; a new item
// is accepted meanwhile, and its result waits until the register frees
// synchronous active-low reset clears the sequencer and output valid
module primitive_root_search #(
    parameter int unsigned VALUE_WIDTH = prs_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned MAX_FACTORS = prs_pkg::DEF_MAX_FACTORS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [prs_pkg::FIELD_WIDTH-1:0]  s_prime_candidate,
    input  logic [prs_pkg::FIELD_WIDTH-1:0]  s_lower_bound,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [prs_pkg::FIELD_WIDTH-1:0]  m_root,
    output logic [1:0]                       m_status
);
    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned CNT_W = $clog2(MAX_FACTORS + 1);
    localparam int unsigned FI_W  = $clog2(MAX_FACTORS);

    prs_pkg::state_t  state_reg, state_next;
    prs_pkg::status_t rstat_reg, rstat_next, ostat_reg;

    logic [W-1:0]     p_reg, x_reg, n_reg, d_reg, g_reg, e_reg, acc_reg, base_reg;
    logic [W-1:0]     n_next, d_next, g_next, e_next, acc_next, base_next;
    logic [W-1:0]     rroot_reg, rroot_next, oroot_reg, phi;
    logic [CNT_W-1:0] cnt_reg, cnt_next, fi_reg, fi_next;
    logic             found_reg, found_next, sq_le_reg, sq_le_next;
    logic             ovalid_reg;

    // factor list memory
    logic [W-1:0]     fac_mem [MAX_FACTORS];
    logic [W-1:0]     fac_rd_reg;
    logic             fac_we;
    logic [W-1:0]     fac_wdata;

    // shared units
    logic             div_start, div_done, mul_start, mul_done;
    logic [W-1:0]     div_a, div_b, div_q, div_r, mul_a, mul_b, mul_res;
    logic [2*W-1:0]   d_sq;

    prs_div #(.VALUE_WIDTH(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    prs_mulmod #(.VALUE_WIDTH(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .m(p_reg),
        .done(mul_done), .res(mul_res)
    );

    assign phi  = p_reg - W'(1);
    assign d_sq = (2*W)'(d_reg) * (2*W)'(d_reg);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            fi_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            fi_reg  <= fi_next;
        end
        if (s_valid && s_ready) begin
            p_reg <= s_prime_candidate[W-1:0];
            x_reg <= s_lower_bound[W-1:0];
        end
        n_reg     <= n_next;
        d_reg     <= d_next;
        g_reg     <= g_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        found_reg <= found_next;
        sq_le_reg <= sq_le_next;
        rroot_reg <= rroot_next;
        rstat_reg <= rstat_next;
    end

    // factor memory write and registered read
    always_ff @(posedge aclk) begin
        if (fac_we) begin
            fac_mem[cnt_reg[FI_W-1:0]] <= fac_wdata;
        end
        fac_rd_reg <= fac_mem[fi_reg[FI_W-1:0]];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (state_reg == prs_pkg::S_FIN && (!ovalid_reg || m_ready)) begin
            ovalid_reg <= 1'b1;
        end else if (m_ready) begin
            ovalid_reg <= 1'b0;
        end
        if (state_reg == prs_pkg::S_FIN && (!ovalid_reg || m_ready)) begin
            oroot_reg <= rroot_reg;
            ostat_reg <= rstat_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        g_next     = g_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        fi_next    = fi_reg;
        found_next = found_reg;
        sq_le_next = sq_le_reg;
        rroot_next = rroot_reg;
        rstat_next = rstat_reg;
        fac_we     = 1'b0;
        fac_wdata  = d_reg;
        div_start  = 1'b0;
        div_a      = p_reg;
        div_b      = d_reg;
        mul_start  = 1'b0;
        mul_a      = acc_reg;
        mul_b      = base_reg;

        case (state_reg)
            prs_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = prs_pkg::S_PT_CHK;
                end
            end
            // small values, divisibility by two, then by three
            prs_pkg::S_PT_CHK: begin
                rroot_next = '0;
                if (p_reg <= W'(1) || (p_reg > W'(3) && !p_reg[0])) begin
                    rstat_next = prs_pkg::STAT_NOT_PRIME;
                    state_next = prs_pkg::S_FIN;
                end else if (p_reg == W'(2)) begin
                    rstat_next = prs_pkg::STAT_TWO;
                    state_next = prs_pkg::S_FIN;
                end else if (p_reg == W'(3)) begin
                    state_next = prs_pkg::S_FA_SH;
                    n_next     = phi;
                end else begin
                    div_start  = 1'b1;
                    div_b      = W'(3);
                    state_next = prs_pkg::S_PT_D3;
                end
            end
            prs_pkg::S_PT_D3: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        rstat_next = prs_pkg::STAT_NOT_PRIME;
                        state_next = prs_pkg::S_FIN;
                    end else begin
                        d_next     = W'(5);
                        state_next = prs_pkg::S_PT_SQ;
                    end
                end
            end
            // 6k-1 and 6k+1 trial divisors up to the square root
            prs_pkg::S_PT_SQ: begin
                sq_le_next = (d_sq <= (2*W)'(p_reg));
                state_next = prs_pkg::S_PT_CMP;
            end
            prs_pkg::S_PT_CMP: begin
                if (!sq_le_reg) begin
                    n_next     = phi;
                    state_next = prs_pkg::S_FA_SH;
                end else begin
                    div_start  = 1'b1;
                    state_next = prs_pkg::S_PT_DA;
                end
            end
            prs_pkg::S_PT_DA: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        rstat_next = prs_pkg::STAT_NOT_PRIME;
                        state_next = prs_pkg::S_FIN;
                    end else begin
                        div_start  = 1'b1;
                        div_b      = d_reg + W'(2);
                        state_next = prs_pkg::S_PT_DB;
                    end
                end
            end
            prs_pkg::S_PT_DB: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        rstat_next = prs_pkg::STAT_NOT_PRIME;
                        state_next = prs_pkg::S_FIN;
                    end else begin
                        d_next     = d_reg + W'(6);
                        state_next = prs_pkg::S_PT_SQ;
                    end
                end
            end
            // p-1 is even: record two and strip its powers
            prs_pkg::S_FA_SH: begin
                if (cnt_reg == '0 && n_reg == phi) begin
                    fac_we    = 1'b1;
                    fac_wdata = W'(2);
                    cnt_next  = CNT_W'(1);
                end
                if (!n_reg[0]) begin
                    n_next = n_reg >> 1;
                end else begin
                    d_next     = W'(3);
                    state_next = prs_pkg::S_FA_SQ;
                end
            end
            prs_pkg::S_FA_SQ: begin
                sq_le_next = (d_sq <= (2*W)'(n_reg));
                state_next = prs_pkg::S_FA_CMP;
            end
            prs_pkg::S_FA_CMP: begin
                if (!sq_le_reg) begin
                    state_next = prs_pkg::S_FA_TAIL;
                end else begin
                    div_start  = 1'b1;
                    div_a      = n_reg;
                    found_next = 1'b0;
                    state_next = prs_pkg::S_FA_DIV;
                end
            end
            // divide out every power of the odd trial divisor
            prs_pkg::S_FA_DIV: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        if (!found_reg && cnt_reg < CNT_W'(MAX_FACTORS)) begin
                            fac_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        found_next = 1'b1;
                        n_next     = div_q;
                        div_start  = 1'b1;
                        div_a      = div_q;
                    end else begin
                        d_next     = d_reg + W'(2);
                        state_next = prs_pkg::S_FA_SQ;
                    end
                end
            end
            // leftover prime cofactor, then set up the search
            prs_pkg::S_FA_TAIL: begin
                if (n_reg > W'(2) && cnt_reg < CNT_W'(MAX_FACTORS)) begin
                    fac_we    = 1'b1;
                    fac_wdata = n_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                fi_next = '0;
                if (x_reg >= phi) begin
                    rstat_next = prs_pkg::STAT_NONE;
                    state_next = prs_pkg::S_FIN;
                end else begin
                    g_next     = x_reg + W'(1);
                    state_next = prs_pkg::S_SR_FAC;
                end
            end
            // walk the factor list for candidate g
            prs_pkg::S_SR_FAC: begin
                if (fi_reg == cnt_reg) begin
                    rroot_next = g_reg;
                    rstat_next = prs_pkg::STAT_FOUND;
                    state_next = prs_pkg::S_FIN;
                end else begin
                    state_next = prs_pkg::S_SR_RD;
                end
            end
            prs_pkg::S_SR_RD: begin
                div_start  = 1'b1;
                div_a      = phi;
                div_b      = fac_rd_reg;
                state_next = prs_pkg::S_SR_DIV;
            end
            prs_pkg::S_SR_DIV: begin
                if (div_done) begin
                    e_next     = div_q;
                    acc_next   = W'(1);
                    base_next  = g_reg;
                    state_next = prs_pkg::S_PW_CHK;
                end
            end
            // square and multiply, exponent bits from the bottom
            prs_pkg::S_PW_CHK: begin
                if (e_reg == '0) begin
                    state_next = prs_pkg::S_PW_END;
                end else if (e_reg[0]) begin
                    mul_start  = 1'b1;
                    state_next = prs_pkg::S_PW_MA;
                end else begin
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    state_next = prs_pkg::S_PW_MB;
                end
            end
            prs_pkg::S_PW_MA: begin
                if (mul_done) begin
                    acc_next   = mul_res;
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    state_next = prs_pkg::S_PW_MB;
                end
            end
            prs_pkg::S_PW_MB: begin
                if (mul_done) begin
                    base_next  = mul_res;
                    e_next     = e_reg >> 1;
                    state_next = prs_pkg::S_PW_CHK;
                end
            end
            // order check: power of one rejects the candidate
            prs_pkg::S_PW_END: begin
                if (acc_reg == W'(1)) begin
                    fi_next = '0;
                    if (g_reg == phi) begin
                        rroot_next = '0;
                        rstat_next = prs_pkg::STAT_NONE;
                        state_next = prs_pkg::S_FIN;
                    end else begin
                        g_next     = g_reg + W'(1);
                        state_next = prs_pkg::S_SR_FAC;
                    end
                end else begin
                    fi_next    = fi_reg + 1'b1;
                    state_next = prs_pkg::S_SR_FAC;
                end
            end
            prs_pkg::S_FIN: begin
                cnt_next = '0;
                fi_next  = '0;
                if (!ovalid_reg || m_ready) begin
                    state_next = prs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = prs_pkg::S_IDLE;
            end
        endcase
    end

    assign s_ready  = (state_reg == prs_pkg::S_IDLE);
    assign m_valid  = ovalid_reg;
    assign m_root   = prs_pkg::FIELD_WIDTH'(oroot_reg);
    assign m_status = ostat_reg;

    // checks
    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == prs_pkg::STAT_FOUND |-> m_root != '0)
        else $error("found result with zero root");

    a_other_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != prs_pkg::STAT_FOUND |-> m_root == '0)
        else $error("root nonzero without found status");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a transfer");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FACTORS) && fi_reg <= cnt_reg)
        else $error("factor count out of range");
endmodule
